// File: rtl/core/sptg_pkg.sv
// ----------------------------------------------------------------------------
// sptg_pkg: shared types, constants and table functions
// Widths of the fixed-point datapath, the register index codes, the sideband
// record that travels down the pipeline and the elaboration-time functions
// that build the ln(1 + e^-u) table.
// ----------------------------------------------------------------------------
package sptg_pkg;

    // Pipeline depth: number of register stages from input to result.
    localparam int NSTAGES   = 8;

    // Datapath widths.
    localparam int VAL_W     = 16;  // Q7.8 values, Q3.12 / Q4.12 coefficients
    localparam int D_W       = 17;  // x - threshold
    localparam int U_W       = 25;  // |d| * alpha in Q12 before range check
    localparam int LUT_W     = 20;  // table entries, Q0.20
    localparam int FRAC_W    = 16;  // interpolation fraction
    localparam int SP_W      = 25;  // softplus in Q20
    localparam int S_W       = 17;  // scaled softplus in Q8, never negative
    localparam int PROD_W    = 34;  // gain * s, signed
    localparam int Q_W       = 22;  // rounded product before clamping
    localparam int CFG_IDX_W = 2;

    localparam logic [VAL_W-1:0] ALPHA_RESET     = 16'd4096;
    localparam logic [VAL_W-1:0] INV_ALPHA_RESET = 16'd4096;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA     = 2'd0,
        CFG_INV_ALPHA = 2'd1
    } cfg_index_t;

    // One load enable per pipeline stage.
    typedef logic [NSTAGES-1:0] stage_vec_t;

    // Per-element record handed from the front end to the back end.
    typedef struct packed {
        logic [FRAC_W-1:0]       frac;      // interpolation weight
        logic [VAL_W-1:0]        u_q12;     // alpha * |d| in Q12, below 16.0
        logic                    pos;       // d > 0
        logic                    fallback;  // |z| reached 16.0
        logic [VAL_W-1:0]        fb_val;    // d when positive, else 0
        logic signed [VAL_W-1:0] gain;
        logic                    last;
    } side_t;

    // Unsigned 64-bit restoring division, used only to build constants.
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] quo;
        logic [63:0] rem;
        int          i;
        quo = '0;
        rem = '0;
        for (i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], a[i]};
            if (rem >= b)
            begin
                rem    = rem - b;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // e^-v in Q30 by a 20-term Taylor series with truncating terms.
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] v);
        logic [63:0] pos_sum;
        logic [63:0] neg_sum;
        logic [63:0] term;
        int          n;
        pos_sum = 64'd1 << 30;
        neg_sum = '0;
        term    = 64'd1 << 30;
        for (n = 1; n <= 20; n++)
        begin
            term = udiv64((term * v) >> 30, 64'(n));
            if (n % 2 == 1)
                neg_sum = neg_sum + term;
            else
                pos_sum = pos_sum + term;
        end
        return (pos_sum > neg_sum) ? (pos_sum - neg_sum) : 64'd0;
    endfunction

    // ln(1 + e) in Q30 through the atanh series.
    function automatic logic [63:0] ln1p_q30(input logic [63:0] e);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] pw;
        logic [63:0] sum;
        int          j;
        t   = udiv64(e << 30, (64'd2 << 30) + e);
        t2  = (t * t) >> 30;
        pw  = t;
        sum = '0;
        for (j = 1; j < 40; j += 2)
        begin
            sum = sum + udiv64(pw, 64'(j));
            pw  = (pw * t2) >> 30;
        end
        return sum << 1;
    endfunction

    // Table entry k of n: ln(1 + e^-(16k/n)) in Q0.20.
    function automatic logic [LUT_W-1:0] lut_entry(input logic [63:0] k, input logic [63:0] n);
        logic [63:0] v;
        logic [63:0] e;
        logic [63:0] l;
        int          sq;
        v = udiv64(k << 30, n);
        e = exp_neg_q30(v);
        for (sq = 0; sq < 4; sq++)
        begin
            e = (e * e + (64'd1 << 29)) >> 30;
        end
        l = (ln1p_q30(e) + 64'd512) >> 10;
        return l[LUT_W-1:0];
    endfunction

endpackage

// File: rtl/core/sptg_if.sv
// ----------------------------------------------------------------------------
// sptg_if: channel interfaces
// Element input channel, result output channel and configuration write
// channel, each with valid/ready flow control.
// ----------------------------------------------------------------------------

// Input elements.
interface sptg_elem_if;
    logic                    valid;
    logic                    ready;
    logic signed [15:0]      x_value;
    logic signed [15:0]      threshold;
    logic signed [15:0]      gain_value;
    logic                    last_in;

    modport source (output valid, x_value, threshold, gain_value, last_in, input ready);
    modport sink   (input valid, x_value, threshold, gain_value, last_in, output ready);
endinterface

// Results.
interface sptg_result_if;
    logic                    valid;
    logic                    ready;
    logic signed [15:0]      result_value;
    logic                    saturated;
    logic                    last_out;

    modport source (output valid, result_value, saturated, last_out, input ready);
    modport sink   (input valid, result_value, saturated, last_out, output ready);
endinterface

// Configuration writes.
interface sptg_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [sptg_pkg::CFG_IDX_W-1:0]    index;
    logic [15:0]                       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/softplus_thresh_gain.sv
// ----------------------------------------------------------------------------
// softplus_thresh_gain: scaled softplus activation with threshold and gain
// y = gain * ln(1 + exp(alpha * (x - threshold))) / alpha in fixed point.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Payload                                   Transaction
//  -------   ---   ---------------------------------------   -----------------
//  elem      in    x_value, threshold, gain_value, last_in   one element
//  result    out   result_value, saturated, last_out         one result
//  cfg       in    index, data                               one register write
//
//  One element per cycle is taken unless the stalled pipeline is full; each
//  result is offered once its element has passed the eight register stages
//  of the pipeline.
//  Configuration writes are taken in every cycle (cfg.ready is always high).
//  rst_n clears the valid bits and returns alpha and inv_alpha to 1.0.
//  A stalled result holds; stages behind it keep filling until the pipeline
//  is full, and only then is elem.ready dropped.
//
module softplus_thresh_gain
#(
    parameter int TABLE_ENTRIES = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    sptg_elem_if.sink              elem,
    sptg_result_if.source          result,
    sptg_cfg_if.sink               cfg
);

    localparam int ADDR_W = $clog2(TABLE_ENTRIES + 1);

    logic [sptg_pkg::VAL_W-1:0]   alpha_reg;
    logic [sptg_pkg::VAL_W-1:0]   inv_alpha_reg;
    sptg_pkg::stage_vec_t         en;
    logic [ADDR_W-1:0]            addr;
    sptg_pkg::side_t              side;
    logic [sptg_pkg::LUT_W-1:0]   lo_val;
    logic [sptg_pkg::LUT_W-1:0]   hi_val;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg     <= sptg_pkg::ALPHA_RESET;
            inv_alpha_reg <= sptg_pkg::INV_ALPHA_RESET;
        end
        else if (cfg.valid)
        begin
            case (sptg_pkg::cfg_index_t'(cfg.index))
                sptg_pkg::CFG_ALPHA:     alpha_reg     <= cfg.data;
                sptg_pkg::CFG_INV_ALPHA: inv_alpha_reg <= cfg.data;
                default:                 ;
            endcase
        end
    end

    // Stage enables and valid bits.
    sptg_pipe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (elem.valid),
        .in_ready  (elem.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .en        (en)
    );

    // Stages 0 to 2.
    sptg_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front
    (
        .clk        (clk),
        .en         (en),
        .x_value    (elem.x_value),
        .threshold  (elem.threshold),
        .gain_value (elem.gain_value),
        .last_in    (elem.last_in),
        .alpha      (alpha_reg),
        .addr       (addr),
        .side       (side)
    );

    // Stage 3 table read.
    sptg_lut #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_lut
    (
        .clk    (clk),
        .load   (en[3]),
        .addr   (addr),
        .lo_val (lo_val),
        .hi_val (hi_val)
    );

    // Stages 3 to 7.
    sptg_back u_back
    (
        .clk          (clk),
        .en           (en),
        .side         (side),
        .lo_val       (lo_val),
        .hi_val       (hi_val),
        .inv_alpha    (inv_alpha_reg),
        .result_value (result.result_value),
        .saturated    (result.saturated),
        .last_out     (result.last_out)
    );

endmodule

// File: rtl/core/sptg_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// sptg_pipe_ctrl: pipeline valid bits and stage enables
// Tracks one valid bit per stage. A stage loads when it is empty or when the
// stage after it moves, so bubbles close up while the output is stalled.
// ----------------------------------------------------------------------------
module sptg_pipe_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output sptg_pkg::stage_vec_t   en
);

    sptg_pkg::stage_vec_t valid_reg;
    sptg_pkg::stage_vec_t valid_next;

    // Enables ripple back from the output register.
    always_comb
    begin
        en[sptg_pkg::NSTAGES-1] = !valid_reg[sptg_pkg::NSTAGES-1] || out_ready;
        for (int k = sptg_pkg::NSTAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    // Valid bits move with the data.
    always_comb
    begin
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < sptg_pkg::NSTAGES; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[sptg_pkg::NSTAGES-1];

endmodule

// File: rtl/core/sptg_front.sv
// ----------------------------------------------------------------------------
// sptg_front: difference, steepness scaling and table addressing
// Stages 0 to 2: x - threshold, alpha * |d| with rounding, range check and
// split of the scaled argument into table index and interpolation fraction.
// ----------------------------------------------------------------------------
module sptg_front
#(
    parameter int TABLE_ENTRIES = 256
)
(
    input  logic                                        clk,
    input  sptg_pkg::stage_vec_t                        en,
    input  logic signed [sptg_pkg::VAL_W-1:0]           x_value,
    input  logic signed [sptg_pkg::VAL_W-1:0]           threshold,
    input  logic signed [sptg_pkg::VAL_W-1:0]           gain_value,
    input  logic                                        last_in,
    input  logic [sptg_pkg::VAL_W-1:0]                  alpha,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0]          addr,
    output sptg_pkg::side_t                             side
);

    localparam int ADDR_W = $clog2(TABLE_ENTRIES + 1);
    localparam int P_W    = sptg_pkg::FRAC_W + ADDR_W;
    localparam int SC_W   = sptg_pkg::D_W + sptg_pkg::VAL_W;

    // Stage 0 registers.
    logic signed [sptg_pkg::D_W-1:0]   d0_reg;
    logic signed [sptg_pkg::VAL_W-1:0] g0_reg;
    logic                              last0_reg;

    // Stage 1 registers.
    logic [sptg_pkg::U_W-1:0]          u1_reg;
    logic                              pos1_reg;
    logic [sptg_pkg::VAL_W-1:0]        fbv1_reg;
    logic signed [sptg_pkg::VAL_W-1:0] g1_reg;
    logic                              last1_reg;

    // Stage 2 registers.
    logic [ADDR_W-1:0]                 addr2_reg;
    sptg_pkg::side_t                   side2_reg;

    logic [sptg_pkg::D_W-1:0]          mag;
    logic [SC_W-1:0]                   scaled;
    logic                              d_pos;
    logic [P_W-1:0]                    pos_in_table;

    // Stage 0: difference to the threshold.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d0_reg    <= $signed({x_value[sptg_pkg::VAL_W-1], x_value})
                       - $signed({threshold[sptg_pkg::VAL_W-1], threshold});
            g0_reg    <= gain_value;
            last0_reg <= last_in;
        end
    end

    // Stage 1: magnitude times alpha, rounded to Q12.
    always_comb
    begin
        mag    = d0_reg[sptg_pkg::D_W-1] ? sptg_pkg::D_W'(-d0_reg) : sptg_pkg::D_W'(d0_reg);
        scaled = SC_W'(mag) * SC_W'(alpha) + SC_W'(128);
        d_pos  = !d0_reg[sptg_pkg::D_W-1] && (d0_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            u1_reg    <= scaled[SC_W-1:8];
            pos1_reg  <= d_pos;
            fbv1_reg  <= d_pos ? d0_reg[sptg_pkg::VAL_W-1:0] : '0;
            g1_reg    <= g0_reg;
            last1_reg <= last0_reg;
        end
    end

    // Stage 2: position in the table, index and fraction.
    assign pos_in_table = P_W'(u1_reg[sptg_pkg::VAL_W-1:0]) * P_W'(TABLE_ENTRIES);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            addr2_reg          <= pos_in_table[P_W-1:sptg_pkg::FRAC_W];
            side2_reg.frac     <= pos_in_table[sptg_pkg::FRAC_W-1:0];
            side2_reg.u_q12    <= u1_reg[sptg_pkg::VAL_W-1:0];
            side2_reg.pos      <= pos1_reg;
            side2_reg.fallback <= |u1_reg[sptg_pkg::U_W-1:sptg_pkg::VAL_W];
            side2_reg.fb_val   <= fbv1_reg;
            side2_reg.gain     <= g1_reg;
            side2_reg.last     <= last1_reg;
        end
    end

    assign addr = addr2_reg;
    assign side = side2_reg;

endmodule

// File: rtl/core/sptg_lut.sv
// ----------------------------------------------------------------------------
// sptg_lut: ln(1 + e^-u) table
// Constant table of TABLE_ENTRIES + 1 points over u in [0, 16], built at
// elaboration. Stage 3 reads the two neighbors of a segment into registers.
// ----------------------------------------------------------------------------
module sptg_lut
#(
    parameter int TABLE_ENTRIES = 256
)
(
    input  logic                                   clk,
    input  logic                                   load,
    input  logic [$clog2(TABLE_ENTRIES+1)-1:0]     addr,
    output logic [sptg_pkg::LUT_W-1:0]             lo_val,
    output logic [sptg_pkg::LUT_W-1:0]             hi_val
);

    localparam int ADDR_W = $clog2(TABLE_ENTRIES + 1);

    logic [sptg_pkg::LUT_W-1:0] rom [0:TABLE_ENTRIES];
    logic [sptg_pkg::LUT_W-1:0] lo_reg;
    logic [sptg_pkg::LUT_W-1:0] hi_reg;
    logic [ADDR_W-1:0]          addr_hi;

    // Table contents, one constant per point.
    for (genvar k = 0; k <= TABLE_ENTRIES; k++)
    begin : g_rom
        localparam logic [sptg_pkg::LUT_W-1:0] ENTRY =
            sptg_pkg::lut_entry(64'(k), 64'(TABLE_ENTRIES));
        assign rom[k] = ENTRY;
    end

    // The index never exceeds TABLE_ENTRIES - 1, so addr + 1 stays in range.
    assign addr_hi = addr + ADDR_W'(1);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lo_reg <= rom[addr];
            hi_reg <= rom[addr_hi];
        end
    end

    assign lo_val = lo_reg;
    assign hi_val = hi_reg;

endmodule

// File: rtl/core/sptg_back.sv
// ----------------------------------------------------------------------------
// sptg_back: interpolation, scaling, gain and saturation
// Stages 3 to 7: linear interpolation between table points, division by alpha
// through its reciprocal, fallback for large arguments, multiplication by the
// gain, rounding and clamping to Q7.8.
// ----------------------------------------------------------------------------
module sptg_back
(
    input  logic                                clk,
    input  sptg_pkg::stage_vec_t                en,
    input  sptg_pkg::side_t                     side,
    input  logic [sptg_pkg::LUT_W-1:0]          lo_val,
    input  logic [sptg_pkg::LUT_W-1:0]          hi_val,
    input  logic [sptg_pkg::VAL_W-1:0]          inv_alpha,
    output logic signed [sptg_pkg::VAL_W-1:0]   result_value,
    output logic                                saturated,
    output logic                                last_out
);

    localparam int W_W  = sptg_pkg::FRAC_W + 1;             // 65536 - frac
    localparam int IP_W = sptg_pkg::LUT_W + W_W;            // interpolation sum
    localparam int SC_W = sptg_pkg::SP_W + sptg_pkg::VAL_W; // sp * inv_alpha

    // Stage 3: sideband next to the table data.
    sptg_pkg::side_t                   side3_reg;

    // Stage 4 registers.
    logic [sptg_pkg::LUT_W-1:0]        f4_reg;
    logic [sptg_pkg::VAL_W-1:0]        u4_reg;
    logic                              pos4_reg;
    logic                              fb4_reg;
    logic [sptg_pkg::VAL_W-1:0]        fbv4_reg;
    logic signed [sptg_pkg::VAL_W-1:0] g4_reg;
    logic                              last4_reg;

    // Stage 5 registers.
    logic [sptg_pkg::S_W-1:0]          s5_reg;
    logic signed [sptg_pkg::VAL_W-1:0] g5_reg;
    logic                              last5_reg;

    // Stage 6 registers.
    logic signed [sptg_pkg::PROD_W-1:0] prod6_reg;
    logic                               last6_reg;

    // Stage 7 registers.
    logic signed [sptg_pkg::VAL_W-1:0] res7_reg;
    logic                              sat7_reg;
    logic                              last7_reg;

    logic [W_W-1:0]                    w_lo;
    logic [IP_W-1:0]                   interp;
    logic [sptg_pkg::SP_W-1:0]         sp;
    logic [SC_W-1:0]                   scaled;
    logic [sptg_pkg::S_W-1:0]          s_val;
    logic signed [sptg_pkg::PROD_W-1:0] rounded;
    logic signed [sptg_pkg::Q_W-1:0]   q_val;

    always_ff @(posedge clk)
    begin
        if (en[3])
            side3_reg <= side;
    end

    // Stage 4: linear interpolation in Q20.
    always_comb
    begin
        w_lo   = W_W'(1) << sptg_pkg::FRAC_W;
        w_lo   = w_lo - W_W'(side3_reg.frac);
        interp = IP_W'(lo_val) * IP_W'(w_lo) + IP_W'(hi_val) * IP_W'(side3_reg.frac);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            f4_reg    <= interp[sptg_pkg::FRAC_W +: sptg_pkg::LUT_W];
            u4_reg    <= side3_reg.u_q12;
            pos4_reg  <= side3_reg.pos;
            fb4_reg   <= side3_reg.fallback;
            fbv4_reg  <= side3_reg.fb_val;
            g4_reg    <= side3_reg.gain;
            last4_reg <= side3_reg.last;
        end
    end

    // Stage 5: add the positive part, scale by 1/alpha, or take the fallback.
    always_comb
    begin
        sp     = (pos4_reg ? {1'b0, u4_reg, 8'd0} : '0) + sptg_pkg::SP_W'(f4_reg);
        scaled = SC_W'(sp) * SC_W'(inv_alpha) + (SC_W'(1) << 23);
        s_val  = fb4_reg ? sptg_pkg::S_W'(fbv4_reg) : scaled[24 +: sptg_pkg::S_W];
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_reg    <= s_val;
            g5_reg    <= g4_reg;
            last5_reg <= last4_reg;
        end
    end

    // Stage 6: gain product.
    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            prod6_reg <= sptg_pkg::PROD_W'(g5_reg) * $signed({1'b0, s5_reg});
            last6_reg <= last5_reg;
        end
    end

    // Stage 7: round half up to Q8 and clamp.
    always_comb
    begin
        rounded = prod6_reg + sptg_pkg::PROD_W'(2048);
        q_val   = rounded[sptg_pkg::PROD_W-1:12];
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            if (q_val > sptg_pkg::Q_W'(32767))
            begin
                res7_reg <= 16'sh7FFF;
                sat7_reg <= 1'b1;
            end
            else if (q_val < -sptg_pkg::Q_W'(32768))
            begin
                res7_reg <= 16'sh8000;
                sat7_reg <= 1'b1;
            end
            else
            begin
                res7_reg <= q_val[sptg_pkg::VAL_W-1:0];
                sat7_reg <= 1'b0;
            end
            last7_reg <= last6_reg;
        end
    end

    assign result_value = res7_reg;
    assign saturated    = sat7_reg;
    assign last_out     = last7_reg;

endmodule

// File: rtl/core/sptg_checker.sv
// ----------------------------------------------------------------------------
// sptg_checker: port-level checks for softplus_thresh_gain
// Watches the channels of the top level and flags flow-control and
// saturation slips.
// ----------------------------------------------------------------------------
module sptg_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        elem_valid,
    input  logic        elem_ready,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [15:0] result_value,
    input  logic        result_saturated,
    input  logic        result_last,
    input  logic        cfg_ready
);

    // A stalled result keeps its payload until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_value) && $stable(result_saturated)
            && $stable(result_last))
        else $error("stalled result changed");

    // A clipped result sits at one of the two range limits.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_saturated |->
            (result_value == 16'h7FFF || result_value == 16'h8000))
        else $error("saturated result not at a limit");

    // With no result waiting, the pipeline can always take an element.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> elem_ready)
        else $error("input stalled with an empty output");

    // A result transaction moves every stage, so the input is open too.
    a_ready_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready |-> elem_ready && cfg_ready)
        else $error("input stalled while the output moved");

endmodule

bind softplus_thresh_gain sptg_checker u_sptg_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .elem_valid       (elem.valid),
    .elem_ready       (elem.ready),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_value     (result.result_value),
    .result_saturated (result.saturated),
    .result_last      (result.last_out),
    .cfg_ready        (cfg.ready)
);
